FILE: rtl/tafsn_pkg.sv
// ----------------------------------------------------------------------------
// tafsn_pkg
// Shared types, character codes and the sequencer control store for the
// ASCII fold and white-space normalizer.
// ----------------------------------------------------------------------------
package tafsn_pkg;

   // Character codes
   localparam logic [20:0] CH_SPACE   = 21'h00_0020;
   localparam logic [20:0] CH_NBSP    = 21'h00_00A0;
   localparam logic [20:0] CH_NEWLINE = 21'h00_000A;

   // Fold modes; the unused code falls through to pass-through.
   localparam logic [1:0] FOLD_PASS    = 2'd0;
   localparam logic [1:0] FOLD_UNICODE = 2'd1;
   localparam logic [1:0] FOLD_WIN1252 = 2'd2;

   // Control register indexes
   localparam logic [2:0] CSR_FOLD_MODE       = 3'd0;
   localparam logic [2:0] CSR_SPACE_BEFORE_NL = 3'd1;
   localparam logic [2:0] CSR_BLANK_LINE      = 3'd2;
   localparam logic [2:0] CSR_KEEP_EOL        = 3'd3;
   localparam logic [2:0] CSR_EOL_FIRST       = 3'd4;
   localparam logic [2:0] CSR_EOL_SECOND      = 3'd5;

   // Folded form of one input: one to three characters, first one wide.
   typedef struct packed {
      logic [1:0]  len;
      logic [20:0] ch0;
      logic [7:0]  ch1;
      logic [7:0]  ch2;
   } fold_result_type;

   // Microcode condition selects
   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_SBN,        // space before newline enabled
      C_SINGLE,     // newline group is one character
      C_NOT_DBL,    // newline group is not doubled
      C_NOT_TWO,    // end-of-line sequence is not two characters
      C_LAST_CHAR   // current folded character is the final one
   } cond_type;

   typedef enum logic [1:0] {
      SRC_SPACE,
      SRC_EOL1,
      SRC_EOL2,
      SRC_CHAR
   } src_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_SET_PEND,
      ACT_CLR_PEND,
      ACT_NEWLINE,
      ACT_VISIBLE
   } act_type;

   typedef logic [3:0] upc_type;

   localparam upc_type PC_SPACE     = 4'd0;
   localparam upc_type PC_NL_REPEAT = 4'd1;
   localparam upc_type PC_NL_SPACE  = 4'd2;
   localparam upc_type PC_NL_FIRST  = 4'd3;
   localparam upc_type PC_NL_SECOND = 4'd4;
   localparam upc_type PC_NL_AGAIN  = 4'd5;
   localparam upc_type PC_NL_AGAIN2 = 4'd6;
   localparam upc_type PC_VIS_SPACE = 4'd7;
   localparam upc_type PC_VIS_CHAR  = 4'd8;

   typedef struct packed {
      cond_type emit_cond;
      src_type  src;
      cond_type last_cond;
      cond_type end_cond;
      cond_type jmp_cond;
      upc_type  jmp_target;
      act_type  act;
   } ucode_type;

   // Control store. A step ends the item, else jumps, else falls through.
   function automatic ucode_type ucode_word(input upc_type pc);
      ucode_type w;
      case (pc)
         PC_SPACE:     w = '{C_NEVER,  SRC_SPACE, C_NEVER,     C_ALWAYS,
                             C_NEVER,  PC_SPACE, ACT_SET_PEND};
         PC_NL_REPEAT: w = '{C_NEVER,  SRC_SPACE, C_NEVER,     C_ALWAYS,
                             C_NEVER,  PC_SPACE, ACT_CLR_PEND};
         PC_NL_SPACE:  w = '{C_SBN,    SRC_SPACE, C_NEVER,     C_NEVER,
                             C_NEVER,  PC_SPACE, ACT_NEWLINE};
         PC_NL_FIRST:  w = '{C_ALWAYS, SRC_EOL1,  C_SINGLE,    C_SINGLE,
                             C_NOT_TWO, PC_NL_AGAIN, ACT_NONE};
         PC_NL_SECOND: w = '{C_ALWAYS, SRC_EOL2,  C_NOT_DBL,   C_NOT_DBL,
                             C_NEVER,  PC_SPACE, ACT_NONE};
         PC_NL_AGAIN:  w = '{C_ALWAYS, SRC_EOL1,  C_NOT_TWO,   C_NOT_TWO,
                             C_NEVER,  PC_SPACE, ACT_NONE};
         PC_NL_AGAIN2: w = '{C_ALWAYS, SRC_EOL2,  C_ALWAYS,    C_ALWAYS,
                             C_NEVER,  PC_SPACE, ACT_NONE};
         PC_VIS_SPACE: w = '{C_ALWAYS, SRC_SPACE, C_NEVER,     C_NEVER,
                             C_NEVER,  PC_SPACE, ACT_CLR_PEND};
         PC_VIS_CHAR:  w = '{C_ALWAYS, SRC_CHAR,  C_LAST_CHAR, C_LAST_CHAR,
                             C_ALWAYS, PC_VIS_CHAR, ACT_VISIBLE};
         default:      w = '{C_NEVER,  SRC_SPACE, C_NEVER,     C_ALWAYS,
                             C_NEVER,  PC_SPACE, ACT_NONE};
      endcase
      return w;
   endfunction

endpackage

FILE: rtl/tafsn_fold.sv
// ----------------------------------------------------------------------------
// tafsn_fold
// Maps one code point to one, two or three characters under the fold mode.
// ----------------------------------------------------------------------------
module tafsn_fold (
   input  logic [20:0]                code_point,
   input  logic [1:0]                 fold_mode,
   output tafsn_pkg::fold_result_type result
);

   // Single-character Unicode punctuation maps; zero when not one of them.
   function automatic logic [7:0] uni_single(input logic [20:0] c);
      logic [7:0] k;
      k = 8'h00;
      if (c >= 21'h2012 && c <= 21'h2015) k = "-";
      if (c == 21'h2016) k = "|";
      if (c == 21'h2017) k = "_";
      if (c >= 21'h2018 && c <= 21'h201B) k = "'";
      if (c >= 21'h201C && c <= 21'h201F) k = "\"";
      if (c == 21'h2022) k = "*";
      return k;
   endfunction

   // Windows-1252 codes 0x80 to 0x9F; zero marks an expanding code.
   function automatic logic [7:0] win_hi(input logic [4:0] i);
      logic [7:0] k;
      case (i)
         5'd1:  k = 8'd129;
         5'd2:  k = ",";
         5'd3:  k = "#";
         5'd4:  k = "\"";
         5'd6:  k = "#";
         5'd7:  k = "#";
         5'd8:  k = "^";
         5'd9:  k = "#";
         5'd10: k = "S";
         5'd11: k = "<";
         5'd13: k = 8'd141;
         5'd14: k = 8'd142;
         5'd15: k = 8'd143;
         5'd16: k = 8'd144;
         5'd17: k = "'";
         5'd18: k = "'";
         5'd19: k = "\"";
         5'd20: k = "\"";
         5'd21: k = "*";
         5'd22: k = "-";
         5'd23: k = "-";
         5'd24: k = "~";
         5'd26: k = "s";
         5'd27: k = ">";
         5'd29: k = 8'd157;
         5'd30: k = 8'd158;
         default: k = 8'h00;
      endcase
      return k;
   endfunction

   function automatic tafsn_pkg::fold_result_type seq3(
      input logic [1:0] n, input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
      tafsn_pkg::fold_result_type r;
      r.len = n;
      r.ch0 = {13'd0, a};
      r.ch1 = b;
      r.ch2 = c;
      return r;
   endfunction

   logic [7:0] single_ch;
   logic [7:0] win_ch;

   always_comb begin
      single_ch  = uni_single(code_point);
      win_ch     = win_hi(code_point[4:0]);
      result.len = 2'd1;
      result.ch0 = code_point;
      result.ch1 = 8'h00;
      result.ch2 = 8'h00;
      case (fold_mode)
         tafsn_pkg::FOLD_UNICODE: begin
            if (single_ch != 8'h00) begin
               result.ch0 = {13'd0, single_ch};
            end else if (code_point == 21'h20AC) begin
               result = seq3(2'd3, "E", "U", "R");
            end else if (code_point == 21'h2026) begin
               result = seq3(2'd3, ".", ".", ".");
            end else if (code_point == 21'h0152) begin
               result = seq3(2'd2, "O", "E", 8'h00);
            end else if (code_point == 21'h2122) begin
               result = seq3(2'd2, "T", "M", 8'h00);
            end else if (code_point == 21'h0153) begin
               result = seq3(2'd2, "o", "e", 8'h00);
            end else if (code_point == 21'h0132) begin
               result = seq3(2'd2, "I", "J", 8'h00);
            end else if (code_point == 21'h0133) begin
               result = seq3(2'd2, "i", "j", 8'h00);
            end
         end
         tafsn_pkg::FOLD_WIN1252: begin
            if (code_point[20:8] == 13'd0) begin
               // Only the 0x80 to 0x9F block goes through the table.
               if (code_point[20:5] == 16'd4) begin
                  if (win_ch != 8'h00) begin
                     result.ch0 = {13'd0, win_ch};
                  end else begin
                     case (code_point[4:0])
                        5'd0:    result = seq3(2'd3, "E", "U", "R");
                        5'd5:    result = seq3(2'd3, ".", ".", ".");
                        5'd12:   result = seq3(2'd2, "O", "E", 8'h00);
                        5'd25:   result = seq3(2'd2, "T", "M", 8'h00);
                        5'd28:   result = seq3(2'd2, "o", "e", 8'h00);
                        default: result = seq3(2'd2, "I", "J", 8'h00);
                     endcase
                  end
               end
            end else if (single_ch != 8'h00) begin
               result.ch0 = {13'd0, single_ch};
            end
         end
         default: begin
            result.len = 2'd1;
         end
      endcase
   end

endmodule

FILE: rtl/text_ascii_fold_space_normalizer_unit.sv
// Flow: the program of an item starts with the first sequencer step after its input transfer;
//    a newline group without a leading space emits nothing in its first step. Each item takes
//    one input transfer and then one sequencer step per step of its program, and no new code
//    point is taken while an item is in flight; a stalled result port holds the sequencer.
// Reset: synchronous; clears the line state and loads the register reset values.
// ----------------------------------------------------------------------------
// text_ascii_fold_space_normalizer_unit
// Folds Unicode code points to ASCII and normalizes spaces and newlines, one
// code point in, zero to five characters out.
// ----------------------------------------------------------------------------
module text_ascii_fold_space_normalizer_unit (
   input  logic        clock,
   input  logic        reset,
   // Input code points
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [20:0] code_point, [23:21] zero
   // Emitted characters
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [20:0] out_char, [23:21] zero
   output logic        rsp_tlast,   // last_of_run
   // Control register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data
);

   // Control registers
   logic [1:0]  fold_mode_ff, fold_mode_in;
   logic        sbn_ff, sbn_in;
   logic        blank_ff, blank_in;
   logic        keep_eol_ff, keep_eol_in;
   logic [7:0]  eol1_ff, eol1_in;
   logic [7:0]  eol2_ff, eol2_in;

   // Line state carried from item to item
   logic [20:0] last_vis_ff, last_vis_in;
   logic        last_nl_ff, last_nl_in;
   logic        pend_ff, pend_in;
   logic        line_text_ff, line_text_in;

   // Sequencer and the folded characters of the item in flight
   logic                  busy_ff, busy_in;
   tafsn_pkg::upc_type    pc_ff, pc_in;
   logic [1:0]            len_ff, len_in;
   logic [20:0]           ch0_ff, ch0_in;
   logic [7:0]            ch1_ff, ch1_in;
   logic [7:0]            ch2_ff, ch2_in;

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [20:0] rsp_char_ff, rsp_char_in;
   logic        rsp_last_ff, rsp_last_in;

   tafsn_pkg::fold_result_type fold_res;
   tafsn_pkg::ucode_type       uword;
   tafsn_pkg::upc_type         entry_pc;
   logic [7:0]                 cond_vec;
   logic                       use_eol, two_char_eol, doubled;
   logic                       emit_now, last_now, end_now, jump_now;
   logic                       out_free, step_fire;
   logic [20:0]                emit_char;

   // ASCII punctuation test on the last visible character.
   function automatic logic is_punct(input logic [20:0] c);
      return (c >= 21'h21 && c <= 21'h2F) || (c >= 21'h3A && c <= 21'h40) ||
             (c >= 21'h5B && c <= 21'h60) || (c >= 21'h7B && c <= 21'h7E);
   endfunction

   tafsn_fold u_fold (
      .code_point (req_tdata[20:0]),
      .fold_mode  (fold_mode_ff),
      .result     (fold_res)
   );

   // Register writes are taken only while no item is in flight, and an offered
   // register write keeps the input closed so that the two never share an edge.
   assign req_tready = !busy_ff && !csr_valid;
   assign csr_ready  = !busy_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;

   // The stored end-of-line sequence is used only when its first character is known.
   assign use_eol      = keep_eol_ff && (eol1_ff != 8'h00);
   assign two_char_eol = use_eol && (eol2_ff != 8'h00);
   assign doubled      = blank_ff && !is_punct(last_vis_ff);

   // Condition lines the control word selects from, indexed by cond_type.
   always_comb begin
      cond_vec                         = 8'h00;
      cond_vec[tafsn_pkg::C_NEVER]     = 1'b0;
      cond_vec[tafsn_pkg::C_ALWAYS]    = 1'b1;
      cond_vec[tafsn_pkg::C_SBN]       = sbn_ff;
      cond_vec[tafsn_pkg::C_SINGLE]    = !two_char_eol && !doubled;
      cond_vec[tafsn_pkg::C_NOT_DBL]   = !doubled;
      cond_vec[tafsn_pkg::C_NOT_TWO]   = !two_char_eol;
      cond_vec[tafsn_pkg::C_LAST_CHAR] = (len_ff <= 2'd1);
   end

   assign uword     = tafsn_pkg::ucode_word(pc_ff);
   assign emit_now  = cond_vec[uword.emit_cond];
   assign last_now  = cond_vec[uword.last_cond];
   assign end_now   = cond_vec[uword.end_cond];
   assign jump_now  = cond_vec[uword.jmp_cond];
   assign out_free  = !rsp_valid_ff || rsp_tready;
   // A step that emits waits until the result register can take its character.
   assign step_fire = busy_ff && (!emit_now || out_free);

   always_comb begin
      case (uword.src)
         tafsn_pkg::SRC_SPACE: emit_char = tafsn_pkg::CH_SPACE;
         tafsn_pkg::SRC_EOL1:  emit_char = use_eol ? {13'd0, eol1_ff} : tafsn_pkg::CH_NEWLINE;
         tafsn_pkg::SRC_EOL2:  emit_char = {13'd0, eol2_ff};
         tafsn_pkg::SRC_CHAR:  emit_char = ch0_ff;
         default:              emit_char = ch0_ff;
      endcase
   end

   // Entry point of the program, chosen from the first folded character and the
   // line state. Expansions start with a letter or a dot, so only a single folded
   // character can be a flat space or a newline.
   always_comb begin
      if (fold_res.ch0 == tafsn_pkg::CH_SPACE || fold_res.ch0 == tafsn_pkg::CH_NBSP) begin
         entry_pc = tafsn_pkg::PC_SPACE;
      end else if (fold_res.ch0 == tafsn_pkg::CH_NEWLINE) begin
         entry_pc = last_nl_ff ? tafsn_pkg::PC_NL_REPEAT : tafsn_pkg::PC_NL_SPACE;
      end else if (line_text_ff && pend_ff) begin
         entry_pc = tafsn_pkg::PC_VIS_SPACE;
      end else begin
         entry_pc = tafsn_pkg::PC_VIS_CHAR;
      end
   end

   // Next-state logic for every register.
   always_comb begin
      fold_mode_in = fold_mode_ff;
      sbn_in       = sbn_ff;
      blank_in     = blank_ff;
      keep_eol_in  = keep_eol_ff;
      eol1_in      = eol1_ff;
      eol2_in      = eol2_ff;
      last_vis_in  = last_vis_ff;
      last_nl_in   = last_nl_ff;
      pend_in      = pend_ff;
      line_text_in = line_text_ff;
      busy_in      = busy_ff;
      pc_in        = pc_ff;
      len_in       = len_ff;
      ch0_in       = ch0_ff;
      ch1_in       = ch1_ff;
      ch2_in       = ch2_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // Register writes are accepted only while the block is idle.
      if (csr_valid && csr_ready) begin
         case (csr_index)
            tafsn_pkg::CSR_FOLD_MODE:       fold_mode_in = csr_data[1:0];
            tafsn_pkg::CSR_SPACE_BEFORE_NL: sbn_in       = csr_data[0];
            tafsn_pkg::CSR_BLANK_LINE:      blank_in     = csr_data[0];
            tafsn_pkg::CSR_KEEP_EOL:        keep_eol_in  = csr_data[0];
            tafsn_pkg::CSR_EOL_FIRST:       eol1_in      = csr_data;
            tafsn_pkg::CSR_EOL_SECOND:      eol2_in      = csr_data;
            default: begin
            end
         endcase
      end

      if (req_tvalid && req_tready) begin
         busy_in = 1'b1;
         pc_in   = entry_pc;
         len_in  = fold_res.len;
         ch0_in  = fold_res.ch0;
         ch1_in  = fold_res.ch1;
         ch2_in  = fold_res.ch2;
      end

      if (step_fire) begin
         if (emit_now) begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = emit_char;
            rsp_last_in  = last_now;
         end
         case (uword.act)
            tafsn_pkg::ACT_SET_PEND: pend_in = 1'b1;
            tafsn_pkg::ACT_CLR_PEND: pend_in = 1'b0;
            tafsn_pkg::ACT_NEWLINE: begin
               pend_in      = 1'b0;
               line_text_in = 1'b0;
               last_nl_in   = 1'b1;
            end
            tafsn_pkg::ACT_VISIBLE: begin
               pend_in      = 1'b0;
               line_text_in = 1'b1;
               last_nl_in   = 1'b0;
               last_vis_in  = ch0_ff;
               // Move the next folded character into place.
               ch0_in = {13'd0, ch1_ff};
               ch1_in = ch2_ff;
               len_in = len_ff - 2'd1;
            end
            default: begin
            end
         endcase
         if (end_now) begin
            busy_in = 1'b0;
         end else if (jump_now) begin
            pc_in = uword.jmp_target;
         end else begin
            pc_in = pc_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_mode_ff <= tafsn_pkg::FOLD_UNICODE;
         sbn_ff       <= 1'b0;
         blank_ff     <= 1'b0;
         keep_eol_ff  <= 1'b0;
         eol1_ff      <= 8'h00;
         eol2_ff      <= 8'h00;
         last_vis_ff  <= 21'd0;
         last_nl_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         line_text_ff <= 1'b0;
         busy_ff      <= 1'b0;
         pc_ff        <= tafsn_pkg::PC_SPACE;
         len_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fold_mode_ff <= fold_mode_in;
         sbn_ff       <= sbn_in;
         blank_ff     <= blank_in;
         keep_eol_ff  <= keep_eol_in;
         eol1_ff      <= eol1_in;
         eol2_ff      <= eol2_in;
         last_vis_ff  <= last_vis_in;
         last_nl_ff   <= last_nl_in;
         pend_ff      <= pend_in;
         line_text_ff <= line_text_in;
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ch0_ff      <= ch0_in;
      ch1_ff      <= ch1_in;
      ch2_ff      <= ch2_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

`ifndef SYNTHESIS
   // An item in flight always has at least one folded character left.
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (len_ff != 2'd0))
      else $error("sequencer busy with no folded character left");

   // The step that ends an item and emits must mark its character as last.
   a_end_marks_last: assert property (@(posedge clock) disable iff (reset)
      (step_fire && emit_now && end_now) |-> last_now)
      else $error("final emitted character not marked last");

   // A character emitted before the end of the item is never marked last.
   a_mid_not_last: assert property (@(posedge clock) disable iff (reset)
      (step_fire && emit_now && !end_now) |-> !last_now)
      else $error("last mark on a character that is not final");

   // Results appear only out of a running program.
   a_result_from_program: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(busy_ff))
      else $error("result offered while the sequencer was idle");
`endif

endmodule

FILE: tb/sv/text_ascii_fold_space_normalizer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_ascii_fold_space_normalizer_unit_tb
// Self-checking bench for the ASCII fold and white-space normalizer. It drives
// code points with random gaps and applies random back-pressure on the result
// port. A behavioral model predicts every emitted character and its
// end-of-item mark, and a monitor compares each result transfer with the
// oldest prediction. The bench covers the fold modes, the newline options and
// the end-of-line settings, at their extremes and at random.
// ----------------------------------------------------------------------------
module text_ascii_fold_space_normalizer_unit_tb;

   // A transfer of any kind resets the watchdog. The slowest legal quiet
   // spell is the long result hold-off below, far under this limit.
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int NUM_PHASES      = 6;
   localparam int ITEMS_PER_PHASE = 46;
   localparam int HOLD_OFF_CYCLES = 80;
   // Cycles allowed after the last expected result, since an item that emits
   // nothing may still be in flight when the block looks drained.
   localparam int SETTLE_CYCLES   = 8;

   // The fold mode code that the block leaves unused, and an index past the
   // last control register; writes there must change nothing.
   localparam logic [1:0] FOLD_UNUSED = 2'd3;
   localparam logic [2:0] CSR_UNUSED  = 3'd6;

   // The 0x80 to 0x9F block of the Windows-1252 page. A zero entry marks a
   // code that expands into several characters.
   localparam logic [7:0] WIN1252_HIGH [32] = '{
      8'h00, 8'd129, 8'h2C, 8'h23, 8'h22, 8'h00, 8'h23, 8'h23,
      8'h5E, 8'h23, 8'h53, 8'h3C, 8'h00, 8'd141, 8'd142, 8'd143,
      8'd144, 8'h27, 8'h27, 8'h22, 8'h22, 8'h2A, 8'h2D, 8'h2D,
      8'h7E, 8'h00, 8'h73, 8'h3E, 8'h00, 8'd157, 8'd158, 8'h00
   };

   // Opening sequence: letters around flat spaces, every Unicode fold entry,
   // repeated newlines, code point zero, the top of the code space and a
   // punctuation mark before a newline.
   localparam logic [20:0] DIRECTED_CODES [25] = '{
      21'h00041, 21'h00020, 21'h000A0, 21'h00062, 21'h02012, 21'h02015,
      21'h02016, 21'h02017, 21'h02018, 21'h0201C, 21'h02022, 21'h020AC,
      21'h02026, 21'h00152, 21'h00153, 21'h02122, 21'h00132, 21'h00133,
      21'h0000A, 21'h0000A, 21'h00020, 21'h00000, 21'h10FFFF, 21'h0002E,
      21'h0000A
   };

   // Code points that the Unicode fold rewrites, plus neighbors that it
   // leaves alone.
   localparam logic [20:0] UNICODE_FOLD_CODES [20] = '{
      21'h02011, 21'h02012, 21'h02013, 21'h02014, 21'h02015, 21'h02016,
      21'h02017, 21'h02018, 21'h0201B, 21'h0201C, 21'h0201F, 21'h02020,
      21'h02022, 21'h020AC, 21'h02026, 21'h02122, 21'h00152, 21'h00153,
      21'h00132, 21'h00133
   };

   localparam logic [20:0] WIN1252_EXPANDING [6] = '{
      21'd128, 21'd133, 21'd140, 21'd153, 21'd156, 21'd159
   };

   typedef struct {
      logic [20:0] ch;
      logic        last;
   } emitted_char_type;

   typedef struct {
      logic [1:0] fold;
      bit         space_before_nl;
      bit         blank_line;
      bit         keep_eol;
      logic [7:0] eol_first;
      logic [7:0] eol_second;
   } reg_setting_type;

   // Predicts the characters that each code point produces and checks the
   // result stream against them in order.
   class char_stream_scoreboard;
      logic [1:0]       fold_mode;
      bit               space_before_nl;
      bit               blank_line;
      bit               keep_eol;
      logic [7:0]       eol_first;
      logic [7:0]       eol_second;
      logic [20:0]      last_visible;
      bit               after_newline;
      bit               space_pending;
      bit               line_started;
      logic [20:0]      item_chars[$];
      emitted_char_type expected_chars[$];
      int               errors;

      function new();
         fold_mode       = tafsn_pkg::FOLD_UNICODE;
         space_before_nl = 1'b0;
         blank_line      = 1'b0;
         keep_eol        = 1'b0;
         eol_first       = 8'h00;
         eol_second      = 8'h00;
         last_visible    = '0;
         after_newline   = 1'b0;
         space_pending   = 1'b0;
         line_started    = 1'b0;
         errors          = 0;
      endfunction

      function void write_reg(logic [2:0] index, logic [7:0] value);
         case (index)
            tafsn_pkg::CSR_FOLD_MODE:       fold_mode       = value[1:0];
            tafsn_pkg::CSR_SPACE_BEFORE_NL: space_before_nl = value[0];
            tafsn_pkg::CSR_BLANK_LINE:      blank_line      = value[0];
            tafsn_pkg::CSR_KEEP_EOL:        keep_eol        = value[0];
            tafsn_pkg::CSR_EOL_FIRST:       eol_first       = value;
            tafsn_pkg::CSR_EOL_SECOND:      eol_second      = value;
            default: ;
         endcase
      endfunction

      function bit is_punct(logic [20:0] c);
         return (c >= 21'h21 && c <= 21'h2F) || (c >= 21'h3A && c <= 21'h40) ||
                (c >= 21'h5B && c <= 21'h60) || (c >= 21'h7B && c <= 21'h7E);
      endfunction

      // No input can cause more than five characters.
      function void put_char(logic [20:0] c);
         if (item_chars.size() < 5)
            item_chars.push_back(c);
      endfunction

      function void normalize(logic [20:0] c);
         int reps;
         if (c == tafsn_pkg::CH_SPACE || c == tafsn_pkg::CH_NBSP) begin
            space_pending = 1'b1;
            return;
         end
         if (c == tafsn_pkg::CH_NEWLINE) begin
            // Only the first newline of a run produces a group.
            if (!after_newline) begin
               if (space_before_nl)
                  put_char(tafsn_pkg::CH_SPACE);
               line_started = 1'b0;
               reps = (blank_line && !is_punct(last_visible)) ? 2 : 1;
               repeat (reps) begin
                  if (keep_eol && eol_first != 8'h00) begin
                     put_char({13'd0, eol_first});
                     if (eol_second != 8'h00)
                        put_char({13'd0, eol_second});
                  end else begin
                     put_char(tafsn_pkg::CH_NEWLINE);
                  end
               end
               after_newline = 1'b1;
            end
         end else begin
            after_newline = 1'b0;
            last_visible  = c;
            if (line_started && space_pending)
               put_char(tafsn_pkg::CH_SPACE);
            put_char(c);
            line_started = 1'b1;
         end
         space_pending = 1'b0;
      endfunction

      function void expand(string s);
         for (int i = 0; i < s.len(); i++)
            normalize({13'd0, s[i]});
      endfunction

      // Single-character Unicode maps; zero when the code point has none.
      function logic [20:0] uni_single(logic [20:0] c);
         if (c >= 21'h2012 && c <= 21'h2015) return 21'h2D;
         if (c == 21'h2016) return 21'h7C;
         if (c == 21'h2017) return 21'h5F;
         if (c >= 21'h2018 && c <= 21'h201B) return 21'h27;
         if (c >= 21'h201C && c <= 21'h201F) return 21'h22;
         if (c == 21'h2022) return 21'h2A;
         return '0;
      endfunction

      function void note_code_point(logic [20:0] cp);
         logic [20:0]      k;
         emitted_char_type e;
         item_chars.delete();
         case (fold_mode)
            tafsn_pkg::FOLD_UNICODE: begin
               k = uni_single(cp);
               if (k != 0)               normalize(k);
               else if (cp == 21'h20AC)  expand("EUR");
               else if (cp == 21'h2026)  expand("...");
               else if (cp == 21'h0152)  expand("OE");
               else if (cp == 21'h2122)  expand("TM");
               else if (cp == 21'h0153)  expand("oe");
               else if (cp == 21'h0132)  expand("IJ");
               else if (cp == 21'h0133)  expand("ij");
               else                      normalize(cp);
            end
            tafsn_pkg::FOLD_WIN1252: begin
               if (cp < 21'd256) begin
                  k = (cp >= 21'd128 && cp < 21'd160) ? {13'd0, WIN1252_HIGH[cp[4:0]]} : cp;
                  if (k == 0 && cp != 0) begin
                     case (cp[7:0])
                        8'd128:  expand("EUR");
                        8'd133:  expand("...");
                        8'd140:  expand("OE");
                        8'd153:  expand("TM");
                        8'd156:  expand("oe");
                        default: expand("IJ");
                     endcase
                  end else begin
                     normalize(k);
                  end
                  // Table codes that expand still count as text on
                  // the line, and so does code point zero.
                  if (k == 0)
                     line_started = 1'b1;
               end else begin
                  // Above the table only the single-character maps apply.
                  k = uni_single(cp);
                  normalize(k != 0 ? k : cp);
               end
            end
            // Pass-through, and the unused mode that behaves the same way.
            default: normalize(cp);
         endcase
         foreach (item_chars[i]) begin
            e.ch   = item_chars[i];
            e.last = (i == item_chars.size() - 1);
            expected_chars.push_back(e);
         end
      endfunction

      function void check_char(logic [20:0] ch, logic last);
         emitted_char_type e;
         if (expected_chars.size() == 0) begin
            errors++;
            $error("unexpected transfer: out_char 0x%0h, last_of_run %0b", ch, last);
            return;
         end
         e = expected_chars.pop_front();
         if (ch !== e.ch) begin
            errors++;
            $error("out_char: expected 0x%0h, actual 0x%0h", e.ch, ch);
         end
         if (last !== e.last) begin
            errors++;
            $error("last_of_run: expected %0b, actual %0b", e.last, last);
         end
      endfunction

      function int pending();
         return expected_chars.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   // When steady is set neither side idles; stall_left counts down a hold-off
   // on the result port that the main sequence requests.
   bit steady = 1'b0;
   int stall_left = 0;

   char_stream_scoreboard scoreboard = new();

   text_ascii_fold_space_normalizer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [20:0] code_point, [23:21] zero
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [20:0] out_char, [23:21] zero
      .rsp_tlast  (rsp_tlast),    // last_of_run
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: the ready line changes only at the falling edge. A requested
   // hold-off keeps it low for a long stretch so that the block backs up and
   // stalls its input; otherwise it drops at random unless the run is steady.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (!steady && $urandom_range(0, 99) < 12) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Every result transfer is checked at the rising edge where it happens.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         scoreboard.check_char(rsp_tdata[20:0], rsp_tlast);
   end

   // Watchdog: ends the run when no transfer of any kind happens for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // Offers one code point, after an optional random gap, and returns at the
   // rising edge where the transfer happens. The valid line is left high so
   // that the next item can follow back to back.
   task automatic send_code_point(input logic [20:0] cp);
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < 12) begin
         req_tvalid <= 1'b0;
         req_tdata  <= {3'b000, 21'($urandom)};
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, cp};
      do @(posedge clock); while (!req_tready);
      scoreboard.note_code_point(cp);
   endtask

   task automatic write_csr(input logic [2:0] index, input logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      scoreboard.write_reg(index, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stops offering input and waits until every predicted character has been
   // seen, then lets the block settle so that it is idle for a register write.
   task automatic finish_phase();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (scoreboard.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Unused upper data bits are filled at random; the registers must ignore
   // them. A write to an index past the last register follows.
   task automatic apply_setting(input reg_setting_type s);
      write_csr(tafsn_pkg::CSR_FOLD_MODE,       {6'($urandom), s.fold});
      write_csr(tafsn_pkg::CSR_SPACE_BEFORE_NL, {7'($urandom), s.space_before_nl});
      write_csr(tafsn_pkg::CSR_BLANK_LINE,      {7'($urandom), s.blank_line});
      write_csr(tafsn_pkg::CSR_KEEP_EOL,        {7'($urandom), s.keep_eol});
      write_csr(tafsn_pkg::CSR_EOL_FIRST,       s.eol_first);
      write_csr(tafsn_pkg::CSR_EOL_SECOND,      s.eol_second);
      write_csr(3'(CSR_UNUSED + $urandom_range(0, 1)), 8'($urandom));
   endtask

   function automatic logic [7:0] pick_eol_char();
      case ($urandom_range(0, 4))
         0:       return 8'h00;
         1:       return 8'h0D;
         2:       return 8'h0A;
         3:       return 8'hFF;
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   // Fixed settings first, covering both extremes of each register except the
   // second end-of-line character, then a random one.
   function automatic reg_setting_type setting_for_phase(int phase);
      reg_setting_type s;
      case (phase)
         1:       s = '{tafsn_pkg::FOLD_PASS,    1'b1, 1'b1, 1'b1, 8'h0D, 8'h0A};
         2:       s = '{tafsn_pkg::FOLD_WIN1252, 1'b0, 1'b1, 1'b1, 8'hFF, 8'hFF};
         3:       s = '{FOLD_UNUSED,             1'b1, 1'b0, 1'b1, 8'h00, 8'h55};
         4:       s = '{tafsn_pkg::FOLD_WIN1252, 1'b1, 1'b1, 1'b0, 8'h0A, 8'h0D};
         default: begin
            s.fold            = 2'($urandom_range(0, 3));
            s.space_before_nl = 1'($urandom);
            s.blank_line      = 1'($urandom);
            s.keep_eol        = 1'($urandom);
            s.eol_first       = pick_eol_char();
            s.eol_second      = pick_eol_char();
         end
      endcase
      return s;
   endfunction

   // Mostly text: words, flat spaces and newlines, with fold codes mixed in,
   // and a share of arbitrary code points over the whole range.
   function automatic logic [20:0] random_code_point();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30)      return 21'($urandom_range(8'h21, 8'h7E));
      else if (r < 42) return tafsn_pkg::CH_SPACE;
      else if (r < 46) return tafsn_pkg::CH_NBSP;
      else if (r < 56) return tafsn_pkg::CH_NEWLINE;
      else if (r < 64) return 21'($urandom_range(128, 255));
      else if (r < 68) return WIN1252_EXPANDING[$urandom_range(0, 5)];
      else if (r < 80) return UNICODE_FOLD_CODES[$urandom_range(0, 19)];
      else if (r < 86) return 21'($urandom_range(0, 31));
      else             return 21'($urandom_range(0, 21'h10FFFF));
   endfunction

   initial begin
      int phase;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed opening under the reset settings (Unicode fold).
      foreach (DIRECTED_CODES[i])
         send_code_point(DIRECTED_CODES[i]);

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase > 0) begin
            finish_phase();
            apply_setting(setting_for_phase(phase));
         end
         // The second phase runs without any idling and holds the result
         // port off once, long enough to fill the block.
         steady = (phase == 1);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_code_point(random_code_point());
            if (phase == 1 && n == 10)
               stall_left = HOLD_OFF_CYCLES;
         end
      end
      finish_phase();

      if (scoreboard.errors == 0 && scoreboard.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: text_ascii_fold_space_normalizer_unit.f
rtl/tafsn_pkg.sv
rtl/tafsn_fold.sv
rtl/text_ascii_fold_space_normalizer_unit.sv
tb/sv/text_ascii_fold_space_normalizer_unit_tb.sv
